### sv/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/sdt_pkg.sv
// types and constants of the scanned device table
package sdt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam logic [4:0] BEACON_MAX = 5'd31;

    // one table entry, also the held query
    typedef struct packed {
        logic [47:0]        addr;
        logic [1:0]         atype;
        logic [7:0]         flags;
        logic signed [7:0]  strength;
        logic [31:0]        rtime;
        logic               beacon;
    } t_entry;

    // probe travelling along the cell row
    typedef struct packed {
        logic               valid;
        logic               found;
        logic signed [7:0]  hit_strength;
        logic [31:0]        old_time;
        logic               old_beacon;
    } t_probe;

    // write control broadcast to the cells
    typedef struct packed {
        logic valid;
        logic is_new;
    } t_wr_ctl;

endpackage

### sv/sdt_report_if.sv
// report channel: one advertising report per word
interface sdt_report_if;
    logic               valid;
    logic               ready;
    logic [47:0]        device_address;
    logic [1:0]         address_type;
    logic [7:0]         adv_flags;
    logic signed [7:0]  signal_strength;
    logic [31:0]        report_time;
    logic               is_beacon;
    logic               payload_empty;

    modport source (output valid, device_address, address_type, adv_flags,
                    signal_strength, report_time, is_beacon, payload_empty,
                    input ready);
    modport sink (input valid, device_address, address_type, adv_flags,
                  signal_strength, report_time, is_beacon, payload_empty,
                  output ready);
endinterface

### sv/sdt_result_if.sv
// result channel: one table update result per word
interface sdt_result_if;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [3:0]         slot;
    logic               was_new;
    logic               evicted;
    logic               focus_hit;
    logic signed [7:0]  focus_prev_strength;
    logic [4:0]         device_count;
    logic [4:0]         beacon_count;

    modport source (output valid, accepted, slot, was_new, evicted, focus_hit,
                    focus_prev_strength, device_count, beacon_count,
                    input ready);
    modport sink (input valid, accepted, slot, was_new, evicted, focus_hit,
                  focus_prev_strength, device_count, beacon_count,
                  output ready);
endinterface

### sv/scanned_device_table.sv
// scanned device table: top level with control and the cell row
// an accepted report is answered after its probe has walked the cell row one
// slot per cycle and the result register is free; an empty report skips the walk
// a new report is taken only in the idle state, one at a time
// reset clears the counters, the focus register and the control state; the
// slot contents are not cleared and only filled slots are ever searched
`include "assert_macros.svh"

module scanned_device_table #(
    parameter int TABLE_DEPTH = sdt_pkg::TABLE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sdt_report_if.sink       i_report,
    sdt_result_if.source     o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [3:0]       i_cfg_data
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state            r_state;
    sdt_pkg::t_entry   r_q;
    logic              r_empty, r_launch;
    logic              r_found, r_old_beacon;
    logic signed [7:0] r_hit_strength;
    logic [IW-1:0]     r_hit_idx, r_old_idx;
    logic [CW-1:0]     r_count;
    logic [4:0]        r_beacon;
    logic [3:0]        r_focus;

    logic              r_out_valid, r_out_accepted, r_out_was_new, r_out_evicted;
    logic              r_out_focus_hit;
    logic [3:0]        r_out_slot;
    logic signed [7:0] r_out_prev;
    logic [4:0]        r_out_dev_count, r_out_beacon_count;

    sdt_pkg::t_probe   w_probe [TABLE_DEPTH+1];
    logic [IW-1:0]     w_hit_idx [TABLE_DEPTH+1];
    logic [IW-1:0]     w_old_idx [TABLE_DEPTH+1];
    sdt_pkg::t_wr_ctl  w_wr;
    logic [IW-1:0]     w_slot;
    logic              w_full, w_new, w_evict, w_hit, w_load;
    logic [CW-1:0]     n_count;
    logic [4:0]        n_beacon, w_beacon_mid;

    // probe enters the first cell for one cycle
    always_comb begin
        w_probe[0] = '0;
        w_probe[0].valid = r_launch;
        w_hit_idx[0] = '0;
        w_old_idx[0] = '0;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        sdt_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_INDEX  (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_probe   (w_probe[g]),
            .i_hit_idx (w_hit_idx[g]),
            .i_old_idx (w_old_idx[g]),
            .o_probe   (w_probe[g+1]),
            .o_hit_idx (w_hit_idx[g+1]),
            .o_old_idx (w_old_idx[g+1]),
            .i_query   (r_q),
            .i_count   (r_count),
            .i_wr      (w_wr),
            .i_wr_idx  (w_slot)
        );
    end

    // decision once the probe has left the row
    always_comb begin
        w_full = (r_count == CW'(TABLE_DEPTH));
        w_new = !r_found;
        w_evict = w_new && w_full;
        w_hit = r_found && (32'(r_hit_idx) == 32'(r_focus));
        if (r_found) begin
            w_slot = r_hit_idx;
        end else if (w_full) begin
            w_slot = r_old_idx;
        end else begin
            w_slot = IW'(r_count);
        end
        n_count = (w_new && !w_full) ? CW'(r_count + 1'b1) : r_count;
        w_beacon_mid = r_beacon;
        if (w_evict && r_old_beacon && r_beacon != 5'd0) begin
            w_beacon_mid = r_beacon - 5'd1;
        end
        n_beacon = w_beacon_mid;
        if (w_new && r_q.beacon && w_beacon_mid != sdt_pkg::BEACON_MAX) begin
            n_beacon = w_beacon_mid + 5'd1;
        end
        w_load = (r_state == S_DONE) && (!r_out_valid || o_result.ready);
        w_wr.valid = w_load && !r_empty;
        w_wr.is_new = w_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_launch <= 1'b0;
            r_count <= '0;
            r_beacon <= '0;
            r_focus <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= (r_state == S_IDLE) && i_report.valid && !i_report.payload_empty;
            if (i_cfg_valid) begin
                r_focus <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_report.valid) begin
                        r_q.addr <= i_report.device_address;
                        r_q.atype <= i_report.address_type;
                        r_q.flags <= i_report.adv_flags;
                        r_q.strength <= i_report.signal_strength;
                        r_q.rtime <= i_report.report_time;
                        r_q.beacon <= i_report.is_beacon;
                        r_empty <= i_report.payload_empty;
                        r_state <= i_report.payload_empty ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_probe[TABLE_DEPTH].valid) begin
                        r_found <= w_probe[TABLE_DEPTH].found;
                        r_hit_strength <= w_probe[TABLE_DEPTH].hit_strength;
                        r_old_beacon <= w_probe[TABLE_DEPTH].old_beacon;
                        r_hit_idx <= w_hit_idx[TABLE_DEPTH];
                        r_old_idx <= w_old_idx[TABLE_DEPTH];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                        if (r_empty) begin
                            r_out_accepted <= 1'b0;
                            r_out_slot <= '0;
                            r_out_was_new <= 1'b0;
                            r_out_evicted <= 1'b0;
                            r_out_focus_hit <= 1'b0;
                            r_out_prev <= '0;
                            r_out_dev_count <= 5'(r_count);
                            r_out_beacon_count <= r_beacon;
                        end else begin
                            r_out_accepted <= 1'b1;
                            r_out_slot <= 4'(w_slot);
                            r_out_was_new <= w_new;
                            r_out_evicted <= w_evict;
                            r_out_focus_hit <= w_hit;
                            r_out_prev <= w_hit ? r_hit_strength : 8'sd0;
                            r_out_dev_count <= 5'(n_count);
                            r_out_beacon_count <= n_beacon;
                            r_count <= n_count;
                            r_beacon <= n_beacon;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_report.ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_result.valid = r_out_valid;
    assign o_result.accepted = r_out_accepted;
    assign o_result.slot = r_out_slot;
    assign o_result.was_new = r_out_was_new;
    assign o_result.evicted = r_out_evicted;
    assign o_result.focus_hit = r_out_focus_hit;
    assign o_result.focus_prev_strength = r_out_prev;
    assign o_result.device_count = r_out_dev_count;
    assign o_result.beacon_count = r_out_beacon_count;

    `ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `ASSERT_IMP(a_probe_in_scan, i_clk, i_rst_n, w_probe[TABLE_DEPTH].valid, r_state == S_SCAN)
    `ASSERT_NXT(a_count_step, i_clk, i_rst_n, w_wr.valid && w_new && !w_full, r_count == CW'($past(r_count) + 1'b1))
    `ASSERT_IMP(a_evict_full, i_clk, i_rst_n, r_out_valid && r_out_evicted, r_out_dev_count == 5'(TABLE_DEPTH))
endmodule

### sv/sdt_cell.sv
// one table slot: stores an entry and updates the passing probe
module sdt_cell #(
    parameter int TABLE_DEPTH = sdt_pkg::TABLE_DEPTH_DEF,
    parameter int CELL_INDEX  = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sdt_pkg::t_probe                   i_probe,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    i_hit_idx,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    i_old_idx,
    output sdt_pkg::t_probe                   o_probe,
    output logic [$clog2(TABLE_DEPTH)-1:0]    o_hit_idx,
    output logic [$clog2(TABLE_DEPTH)-1:0]    o_old_idx,
    input  sdt_pkg::t_entry                   i_query,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]  i_count,
    input  sdt_pkg::t_wr_ctl                  i_wr,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    i_wr_idx
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

    sdt_pkg::t_entry r_e;
    sdt_pkg::t_probe r_probe, n_probe;
    logic [IW-1:0]   r_hit_idx, n_hit_idx, r_old_idx, n_old_idx;
    logic            w_match, w_older;

    assign w_match = i_probe.valid && !i_probe.found
                     && (CW'(CELL_INDEX) < i_count) && (r_e.addr == i_query.addr);
    // first cell seeds the oldest search, later cells need strictly older
    assign w_older = (CELL_INDEX == 0) || (r_e.rtime < i_probe.old_time);

    always_comb begin
        n_probe = i_probe;
        n_hit_idx = i_hit_idx;
        n_old_idx = i_old_idx;
        if (w_match) begin
            n_probe.found = 1'b1;
            n_probe.hit_strength = r_e.strength;
            n_hit_idx = MY_IDX;
        end
        if (w_older) begin
            n_probe.old_time = r_e.rtime;
            n_probe.old_beacon = r_e.beacon;
            n_old_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe.valid;
        end
        r_probe.found <= n_probe.found;
        r_probe.hit_strength <= n_probe.hit_strength;
        r_probe.old_time <= n_probe.old_time;
        r_probe.old_beacon <= n_probe.old_beacon;
        r_hit_idx <= n_hit_idx;
        r_old_idx <= n_old_idx;
    end

    // address, type and flags keep their first values on a refresh
    always_ff @(posedge i_clk) begin
        if (i_wr.valid && i_wr_idx == MY_IDX) begin
            r_e.strength <= i_query.strength;
            r_e.rtime <= i_query.rtime;
            r_e.beacon <= i_query.beacon;
            if (i_wr.is_new) begin
                r_e.addr <= i_query.addr;
                r_e.atype <= i_query.atype;
                r_e.flags <= i_query.flags;
            end
        end
    end

    assign o_probe = r_probe;
    assign o_hit_idx = r_hit_idx;
    assign o_old_idx = r_old_idx;
endmodule

### sim/scanned_device_table_checker.sv
// scanned device table checker: watches the channels, predicts each answer and compares
module scanned_device_table_checker #(
    parameter int TABLE_DEPTH = sdt_pkg::TABLE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sdt_report_if   i_report,
    sdt_result_if   i_result,
    input  logic    i_cfg_valid,
    input  logic    i_cfg_ready,
    input  logic [3:0] i_cfg_data,
    output int      o_fail_count,
    output int      o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BEACON_CEILING = 31;

    typedef struct packed {
        logic               accepted;
        logic [3:0]         slot;
        logic               was_new;
        logic               evicted;
        logic               focus_hit;
        logic signed [7:0]  prev_strength;
        logic [4:0]         device_count;
        logic [4:0]         beacon_count;
    } t_table_answer;

    logic [47:0]        known_addr     [TABLE_DEPTH];
    logic signed [7:0]  known_strength [TABLE_DEPTH];
    logic [31:0]        last_seen      [TABLE_DEPTH];
    logic               known_beacon   [TABLE_DEPTH];
    int                 filled;
    int                 beacons;
    logic [3:0]         focus;
    t_table_answer      answers_due[$];
    t_table_answer      want;

    // search, insert or evict, and return the answer the block must give
    function automatic t_table_answer apply_report(input logic [47:0] addr,
                                                   input logic signed [7:0] strength,
                                                   input logic [31:0] stamp,
                                                   input logic beacon,
                                                   input logic empty);
        t_table_answer ans;
        int idx;
        int i;
        bit found;
        ans = '0;
        idx = 0;
        found = 1'b0;
        if (!empty) begin
            ans.accepted = 1'b1;
            for (i = 0; i < filled; i++) begin
                if (!found && known_addr[i] == addr) begin
                    found = 1'b1;
                    idx = i;
                end
            end
            if (!found) begin
                ans.was_new = 1'b1;
                if (filled < TABLE_DEPTH) begin
                    idx = filled;
                    filled++;
                end else begin
                    // strictly older wins, so ties stay on the lowest index
                    for (i = 1; i < TABLE_DEPTH; i++)
                        if (last_seen[i] < last_seen[idx])
                            idx = i;
                    ans.evicted = 1'b1;
                    if (known_beacon[idx] && beacons > 0)
                        beacons--;
                end
                if (beacon && beacons < BEACON_CEILING)
                    beacons++;
                known_addr[idx] = addr;
            end else if (idx == int'(focus)) begin
                ans.focus_hit = 1'b1;
                ans.prev_strength = known_strength[idx];
            end
            known_strength[idx] = strength;
            last_seen[idx] = stamp;
            known_beacon[idx] = beacon;
        end
        ans.slot = idx[3:0];
        ans.device_count = filled[4:0];
        ans.beacon_count = beacons[4:0];
        return ans;
    endfunction

    task automatic check_field(input string field, input longint expected,
                               input longint actual);
        if (expected != actual) begin
            $error("%s: expected %0d, actual %0d", field, expected, actual);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            filled = 0;
            beacons = 0;
            focus = '0;
            answers_due.delete();
            o_fail_count = 0;
            o_outstanding <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                focus = i_cfg_data;
            if (i_report.valid && i_report.ready)
                answers_due.push_back(apply_report(i_report.device_address,
                                                   i_report.signal_strength,
                                                   i_report.report_time,
                                                   i_report.is_beacon,
                                                   i_report.payload_empty));
            if (i_result.valid && i_result.ready) begin
                if (answers_due.size() == 0) begin
                    $error("result word with no report waiting for it");
                    o_fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    check_field("accepted", want.accepted, i_result.accepted);
                    check_field("slot", want.slot, i_result.slot);
                    check_field("was_new", want.was_new, i_result.was_new);
                    check_field("evicted", want.evicted, i_result.evicted);
                    check_field("focus_hit", want.focus_hit, i_result.focus_hit);
                    check_field("focus_prev_strength", want.prev_strength,
                                i_result.focus_prev_strength);
                    check_field("device_count", want.device_count,
                                i_result.device_count);
                    check_field("beacon_count", want.beacon_count,
                                i_result.beacon_count);
                end
            end
            o_outstanding <= answers_due.size();
        end
    end

endmodule

### sim/scanned_device_table_tb.sv
// scanned device table testbench: reset, stimulus, idling and verdict
module scanned_device_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = sdt_pkg::TABLE_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 400;
    localparam int PHASE_WORDS = 250;
    localparam int PHASES      = 6;
    localparam int POOL_SIZE   = 24;
    localparam logic [47:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [47:0]        addr;
        logic [1:0]         atype;
        logic [7:0]         flags;
        logic signed [7:0]  strength;
        logic [31:0]        stamp;
        logic               beacon;
        logic               empty;
    } t_report;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_data = 4'd0;
    int         fail_count;
    int         outstanding;
    int         send_burst = 0;
    int         take_burst = 0;
    int         quiet = 0;
    logic [47:0] pool [POOL_SIZE];

    sdt_report_if report_ch();
    sdt_result_if result_ch();

    scanned_device_table #(.TABLE_DEPTH(DEPTH)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_report    (report_ch),
        .o_result    (result_ch),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    scanned_device_table_checker #(.TABLE_DEPTH(DEPTH)) table_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_report      (report_ch),
        .i_result      (result_ch),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #4 clk = ~clk;

    // mostly random gaps, now and then a run of back-to-back words
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            burst = $urandom_range(8, 40);
        return $urandom_range(0, 11);
    endfunction

    function automatic t_report make_report(input logic [47:0] addr, input logic [1:0] atype,
                                            input logic [7:0] flags,
                                            input logic signed [7:0] strength,
                                            input logic [31:0] stamp, input logic beacon,
                                            input logic empty);
        t_report r;
        r.addr = addr;
        r.atype = atype;
        r.flags = flags;
        r.strength = strength;
        r.stamp = stamp;
        r.beacon = beacon;
        r.empty = empty;
        return r;
    endfunction

    function automatic logic [47:0] fresh_addr();
        return 48'({$urandom(), $urandom()});
    endfunction

    // addresses mostly from a pool a bit larger than the table, so hits and
    // evictions both happen; timestamps mostly rising with repeats
    function automatic t_report random_report(inout logic [31:0] clock_now);
        t_report r;
        int pick;
        pick = $urandom_range(0, 99);
        r.addr = (pick < 80) ? pool[$urandom_range(0, POOL_SIZE - 1)] : fresh_addr();
        r.atype = 2'($urandom_range(0, 3));
        r.flags = 8'($urandom());
        r.strength = 8'($urandom());
        pick = $urandom_range(0, 19);
        if (pick == 0)
            r.stamp = $urandom();
        else if (pick == 1)
            r.stamp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        else begin
            clock_now += $urandom_range(0, 40);
            r.stamp = clock_now;
        end
        r.beacon = 1'($urandom_range(0, 1));
        r.empty = ($urandom_range(0, 9) == 0);
        return r;
    endfunction

    task automatic send_report(input t_report r);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            report_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        report_ch.device_address  <= r.addr;
        report_ch.address_type    <= r.atype;
        report_ch.adv_flags       <= r.flags;
        report_ch.signal_strength <= r.strength;
        report_ch.report_time     <= r.stamp;
        report_ch.is_beacon       <= r.beacon;
        report_ch.payload_empty   <= r.empty;
        report_ch.valid           <= 1'b1;
        @(posedge clk);
        while (!report_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // register written only once every answer is back
    task automatic set_focus(input logic [3:0] value);
        report_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        int gap;
        int taken;
        bit held;
        taken = 0;
        held = 1'b0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (!held && taken == HOLD_AFTER) begin
                held = 1'b1;
                gap = HOLD_CYCLES;
            end else
                gap = draw_gap(take_burst);
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(result_ch.valid && result_ch.ready)) @(posedge clk);
            taken++;
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((report_ch.valid && report_ch.ready) ||
                (result_ch.valid && result_ch.ready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet + 1 >= STALL_LIMIT) begin
                $display("scanned_device_table: mismatch");
                $finish;
            end else
                quiet <= quiet + 1;
        end
    end

    initial begin
        t_report r;
        logic [31:0] clock_now;
        logic [3:0] focus_plan [PHASES];
        int useful;
        int i;
        bit up;

        report_ch.valid = 1'b0;
        report_ch.device_address = '0;
        report_ch.address_type = '0;
        report_ch.adv_flags = '0;
        report_ch.signal_strength = '0;
        report_ch.report_time = '0;
        report_ch.is_beacon = 1'b0;
        report_ch.payload_empty = 1'b0;
        focus_plan = '{4'd15, 4'd1, 4'd0, 4'd15, 4'd0, 4'd7};
        focus_plan[5] = 4'($urandom_range(0, 15));
        pool[0] = '0;
        pool[1] = ADDR_ONES;
        for (i = 2; i < POOL_SIZE; i++)
            pool[i] = fresh_addr();
        clock_now = 32'd1000;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // focus beyond the filled slots: the repeat below must not flag
        set_focus(4'd15);
        send_report(make_report(ADDR_ONES, 2'd3, 8'hFF, 8'sd127, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_report(make_report(48'd0, 2'd0, 8'h00, -8'sd128, 32'd0, 1'b1, 1'b0));
        send_report(make_report(48'd0, 2'd3, 8'hFF, 8'sd127, 32'd5, 1'b0, 1'b0));
        set_focus(4'd0);
        send_report(make_report(48'd0, 2'd1, 8'h5A, -8'sd5, 32'd6, 1'b1, 1'b0));
        // fill up, two slots share the oldest stamp
        for (i = 1; i < DEPTH; i++)
            send_report(make_report((i == 1) ? ADDR_ONES : pool[i + 1], 2'(i), 8'($urandom()),
                                    8'($urandom()), (i == 3 || i == 9) ? 32'd1 : 32'(100 + i),
                                    1'(i), 1'b0));
        send_report(make_report(fresh_addr(), 2'd2, 8'h81, 8'sd0, 32'd50, 1'b1, 1'b0));
        send_report(make_report(fresh_addr(), 2'd1, 8'h18, -8'sd1, 32'd51, 1'b0, 1'b0));
        send_report(make_report(fresh_addr(), 2'd0, 8'h00, 8'sd3, 32'd52, 1'b1, 1'b1));
        send_report(make_report(48'd0, 2'd2, 8'h11, 8'sd64, 32'd53, 1'b0, 1'b0));

        for (int phase = 0; phase < PHASES; phase++) begin
            set_focus(focus_plan[phase]);
            for (i = 0; i < 6; i++)
                pool[$urandom_range(2, POOL_SIZE - 1)] = fresh_addr();
            // early phases push the beacon counter up, later ones down
            up = (phase < PHASES / 2);
            useful = 0;
            while (useful < PHASE_WORDS) begin
                if ($urandom_range(0, 99) < 30) begin
                    // new address stamped oldest, then a repeat flipping its
                    // beacon bit so its later eviction skews the counter
                    r = random_report(clock_now);
                    r.addr = fresh_addr();
                    r.stamp = '0;
                    r.beacon = up;
                    r.empty = 1'b0;
                    send_report(r);
                    r.beacon = !up;
                    r.strength = 8'($urandom());
                    send_report(r);
                    useful += 2;
                end else begin
                    r = random_report(clock_now);
                    send_report(r);
                    if (!r.empty)
                        useful++;
                end
            end
        end

        report_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DEPTH + 3) @(posedge clk);
        if (fail_count == 0)
            $display("scanned_device_table: match");
        else
            $display("scanned_device_table: mismatch");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/sdt_pkg.sv
sv/sdt_report_if.sv
sv/sdt_result_if.sv
sv/sdt_cell.sv
sv/scanned_device_table.sv
sim/scanned_device_table_checker.sv
sim/scanned_device_table_tb.sv
